@@ rtl/command_packet_slip_framer_macros.svh @@
// Assertion macros used by the framer's emitter.
`ifndef COMMAND_PACKET_SLIP_FRAMER_MACROS_SVH
`define COMMAND_PACKET_SLIP_FRAMER_MACROS_SVH
`ifndef SYNTH
`define CPSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpsf assertion failed");
`define CPSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpsf assertion failed");
`else
`define CPSF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CPSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cpsf_pkg.sv @@
package cpsf_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Position of the emitter inside one item.
  typedef logic [3:0] pos_t;
  localparam pos_t POS_OPEN  = 4'd0;
  localparam pos_t POS_HDR0  = 4'd1;
  localparam pos_t POS_DATA  = 4'd9;
  localparam pos_t POS_CLOSE = 4'd10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } wire_byte_t;

endpackage

@@ rtl/cpsf_in_if.sv @@
interface cpsf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [15:0] payload_length;
  logic [31:0] payload_checksum;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;

  modport source (
    output valid, opcode, payload_length, payload_checksum, data_byte,
           first_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, payload_length, payload_checksum, data_byte,
           first_byte, last_byte,
    output ready
  );
endinterface

@@ rtl/cpsf_out_if.sv @@
interface cpsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;

  modport source (output valid, out_byte, end_of_frame, input ready);
  modport sink (input valid, out_byte, end_of_frame, output ready);
endinterface

@@ rtl/cpsf_emitter.sv @@
`include "command_packet_slip_framer_macros.svh"

module cpsf_emitter
  import cpsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cpsf_in_if.sink    cmd,
  output logic       emit_valid,
  output wire_byte_t emit,
  input  logic       emit_ready
);

  logic        cur_valid;
  logic        in_frame;
  logic        esc_half;
  pos_t        pos;
  logic [63:0] header_shadow;
  logic [7:0]  cur_data;
  logic        cur_last;

  logic [2:0]  hdr_idx;
  logic [7:0]  raw;
  logic        esc_ok;
  logic        eof;
  logic        need_esc;
  logic        byte_end;
  logic        item_end;
  logic        step;
  logic        accept;
  logic        esc_tail;
  pos_t        pos_next;

  assign hdr_idx = 3'(pos - POS_HDR0);

  always_comb begin
    raw    = header_shadow[{hdr_idx, 3'b000} +: 8];
    esc_ok = 1'b1;
    eof    = 1'b0;
    if (pos == POS_OPEN) begin
      raw    = SLIP_END;
      esc_ok = 1'b0;
    end else if (pos == POS_CLOSE) begin
      raw    = SLIP_END;
      esc_ok = 1'b0;
      eof    = 1'b1;
    end else if (pos == POS_DATA) begin
      raw = cur_data;
    end
  end

  assign need_esc = esc_ok && (raw == SLIP_END || raw == SLIP_ESC);
  assign byte_end = !need_esc || esc_half;
  assign item_end = byte_end && ((pos == POS_DATA && !cur_last) || pos == POS_CLOSE);
  assign pos_next = (pos == POS_DATA) ? POS_CLOSE : pos + 4'd1;

  always_comb begin
    emit.end_of_frame = eof;
    if (esc_half) begin
      emit.out_byte = (raw == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
    end else if (need_esc) begin
      emit.out_byte = SLIP_ESC;
    end else begin
      emit.out_byte = raw;
    end
  end

  assign esc_tail = (emit.out_byte == SLIP_ESC_END) || (emit.out_byte == SLIP_ESC_ESC);

  assign emit_valid = cur_valid;
  assign step       = cur_valid && emit_ready;
  assign cmd.ready  = !cur_valid || (step && item_end);
  assign accept     = cmd.valid && cmd.ready;

  // An accept while an item is held only happens on the last byte of that
  // item, so the new item simply replaces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      in_frame      <= 1'b0;
      esc_half      <= 1'b0;
      header_shadow <= '0;
    end else if (accept) begin
      cur_data <= cmd.data_byte;
      cur_last <= cmd.last_byte;
      esc_half <= 1'b0;
      if (cmd.first_byte) begin
        header_shadow <= {cmd.payload_checksum, cmd.payload_length, cmd.opcode, 8'h00};
        in_frame      <= !cmd.last_byte;
        cur_valid     <= 1'b1;
        pos           <= POS_OPEN;
      end else if (in_frame) begin
        in_frame  <= !cmd.last_byte;
        cur_valid <= 1'b1;
        pos       <= POS_DATA;
      end else begin
        cur_valid <= 1'b0;
      end
    end else if (step) begin
      if (byte_end) begin
        esc_half <= 1'b0;
        if (item_end) begin
          cur_valid <= 1'b0;
        end else begin
          pos <= pos_next;
        end
      end else begin
        esc_half <= 1'b1;
      end
    end
  end

  `CPSF_ASSERT_IMP(a_esc_within_item, clk, rst, esc_half, cur_valid)
  `CPSF_ASSERT_IMP(a_close_needs_last, clk, rst, cur_valid && pos == POS_CLOSE, cur_last)
  `CPSF_ASSERT_IMP(a_esc_second_byte, clk, rst, step && esc_half, esc_tail)
  `CPSF_ASSERT_NEXT(a_item_holds, clk, rst, cur_valid && !step, cur_valid)

endmodule

@@ rtl/cpsf_out_reg.sv @@
module cpsf_out_reg
  import cpsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       emit_valid,
  input  wire_byte_t emit,
  output logic       emit_ready,
  cpsf_out_if.source slip
);

  logic       valid;
  wire_byte_t held;

  assign emit_ready        = !valid || slip.ready;
  assign slip.valid        = valid;
  assign slip.out_byte     = held.out_byte;
  assign slip.end_of_frame = held.end_of_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit_ready) begin
      valid <= emit_valid;
      if (emit_valid) begin
        held <= emit;
      end
    end
  end

endmodule

@@ rtl/command_packet_slip_framer.sv @@
// Command packet SLIP framer.
// The cmd channel takes one payload byte per item together with its frame
// marks; on an item with first_byte set, opcode, payload_length and
// payload_checksum are sampled for the header. The slip channel gives one
// wire byte per item: an opening 0xC0, the eight header bytes, the payload
// bytes, and a closing 0xC0 flagged by end_of_frame, with 0xC0 and 0xDB
// escaped as DB DC and DB DD. Items that arrive with no frame open and
// without first_byte are taken and dropped.
// An accepted item is held in the emitter, which hands one wire byte per
// cycle to the output register while that register can take it, so the
// first byte of an item passes the emitter and then the output register
// before it is valid on slip. An item makes one wire byte for a plain
// payload byte, two for an escaped one, and up to twenty when it opens
// and closes a frame. The next item is taken in the cycle the last byte
// of the current one moves to the output register.
// Synchronous reset empties both stages and closes any open frame. When
// the receiver stalls, the output register holds its byte, the emitter
// holds its item, and cmd.ready falls once the emitter is busy.
module command_packet_slip_framer
  import cpsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cpsf_in_if.sink    cmd,
  cpsf_out_if.source slip
);

  logic       emit_valid;
  logic       emit_ready;
  wire_byte_t emit;

  cpsf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  cpsf_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ready (emit_ready),
    .slip       (slip)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cpsf_pkg::*;

  // One command item as the sender offers it, plus the sender's own pacing:
  // how many cycles to idle before offering it, and whether to wait for the
  // wire stream to drain completely first.
  typedef struct {
    logic [7:0]  opcode;
    logic [15:0] length;
    logic [31:0] checksum;
    logic [7:0]  data;
    logic        first;
    logic        last;
    int unsigned gap;
    bit          drain;
  } cmd_item_t;

  // The run is about 430 items of at most 20 wire bytes each, every byte
  // waiting on a random receiver stall, plus sender gaps and one long
  // hold-off; the limit is set well above the length of such a run.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic clk;
  logic rst;

  cpsf_in_if  cmd_if ();
  cpsf_out_if slip_if ();

  command_packet_slip_framer i_dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_if),
    .slip (slip_if)
  );

  // Items not yet offered, and the wire bytes the framer still owes us.
  cmd_item_t  payload_items_q[$];
  wire_byte_t slip_bytes_q[$];

  // Our own copy of the framer state: whether a frame is open and the raw
  // header bytes of that frame.
  logic        frame_open;
  logic [63:0] hdr_shadow;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned slip_count;
  bit          calm_stretch;

  // Handshake flags raised by the monitor at the rising edge and consumed
  // by the driver and the receiver at the following falling edge.
  bit cmd_took;
  bit slip_took;

  // Driver state.
  cmd_item_t   staged_item;
  bit          staged;
  int unsigned wait_left;

  // Receiver state.
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction. A frame opens with 0xC0, then eight header bytes (direction 0,
  // opcode, length LE, checksum LE), then the payload, and closes with 0xC0
  // flagged as end of frame. Header and payload bytes equal to 0xC0 or 0xDB
  // are escaped into two bytes each.
  // ---------------------------------------------------------------------------
  task automatic push_wire(input logic [7:0] value, input logic eof);
    wire_byte_t w;
    w.out_byte     = value;
    w.end_of_frame = eof;
    slip_bytes_q.push_back(w);
  endtask

  task automatic push_escaped(input logic [7:0] value);
    if (value == SLIP_END) begin
      push_wire(SLIP_ESC, 1'b0);
      push_wire(SLIP_ESC_END, 1'b0);
    end else if (value == SLIP_ESC) begin
      push_wire(SLIP_ESC, 1'b0);
      push_wire(SLIP_ESC_ESC, 1'b0);
    end else begin
      push_wire(value, 1'b0);
    end
  endtask

  task automatic frame_and_escape(input cmd_item_t it);
    // A first byte always starts a fresh frame, even when one is still open;
    // the old frame is simply dropped with no closing delimiter.
    if (it.first) begin
      hdr_shadow = {it.checksum, it.length, it.opcode, 8'h00};
      frame_open = 1'b1;
      push_wire(SLIP_END, 1'b0);
      for (int i = 0; i < 8; i++) begin
        push_escaped(hdr_shadow[8*i +: 8]);
      end
    end
    // Outside a frame the item is dropped, its last mark included.
    if (frame_open) begin
      push_escaped(it.data);
      if (it.last) begin
        push_wire(SLIP_END, 1'b1);
        frame_open = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Byte values with a strong lean toward the two that need escaping and the
  // two extremes.
  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 7))
      0: pick8 = SLIP_END;
      1: pick8 = SLIP_ESC;
      2: pick8 = 8'h00;
      3: pick8 = 8'hFF;
      default: pick8 = 8'($urandom);
    endcase
  endfunction

  task automatic add_item(input logic [7:0] op, input logic [15:0] len,
                          input logic [31:0] cs, input logic [7:0] dat,
                          input logic first, input logic last, input bit drain);
    cmd_item_t it;
    it.opcode   = op;
    it.length   = len;
    it.checksum = cs;
    it.data     = dat;
    it.first    = first;
    it.last     = last;
    it.drain    = drain;
    it.gap      = calm_stretch ? 0 : $urandom_range(0, 13);
    payload_items_q.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Items change at the falling edge. An offered item stays put until
  // the monitor sees it taken; then the next one is staged, waits out its gap
  // (and, when asked, the complete drain of the wire stream) and is offered.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    logic offer;
    if (!rst) begin
      offer    = cmd_if.valid && !cmd_took;
      cmd_took = 1'b0;
      if (!offer) begin
        if (!staged && payload_items_q.size() != 0) begin
          staged_item = payload_items_q.pop_front();
          staged      = 1'b1;
          wait_left   = staged_item.gap;
        end
        if (staged && wait_left > 0) begin
          wait_left--;
        end else if (staged && !(staged_item.drain && slip_bytes_q.size() != 0)) begin
          cmd_if.opcode           = staged_item.opcode;
          cmd_if.payload_length   = staged_item.length;
          cmd_if.payload_checksum = staged_item.checksum;
          cmd_if.data_byte        = staged_item.data;
          cmd_if.first_byte       = staged_item.first;
          cmd_if.last_byte        = staged_item.last;
          staged                  = 1'b0;
          offer                   = 1'b1;
        end
      end
      cmd_if.valid = offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. After each wire byte it draws a stall. In some stretches it
  // never stalls at all. Once, a few hundred bytes in, it holds off for a
  // long time so that the framer backs up and drops cmd.ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (slip_took) begin
        slip_took  = 1'b0;
        stall_left = (((slip_count / 256) % 4) == 1) ? 0 : $urandom_range(0, 13);
        if (slip_count >= HOLD_AT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        slip_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        slip_if.ready = 1'b0;
      end else begin
        slip_if.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Both handshakes are sampled at the rising edge. A wire byte is
  // checked against the oldest expected byte before any item taken at the
  // same edge is predicted; that item's bytes must still pass the emitter
  // and the output register before they can appear anyway.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cmd_item_t  seen;
    wire_byte_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end else if (!rst) begin
      if (slip_if.valid && slip_if.ready) begin
        slip_took = 1'b1;
        slip_count++;
        if (slip_bytes_q.size() == 0) begin
          $display("%0t: unexpected wire byte: expected none, actual %h eof %b", $time,
                   slip_if.out_byte, slip_if.end_of_frame);
          mismatch_count++;
        end else begin
          want = slip_bytes_q.pop_front();
          if (slip_if.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h", $time,
                     want.out_byte, slip_if.out_byte);
            mismatch_count++;
          end
          if (slip_if.end_of_frame !== want.end_of_frame) begin
            $display("%0t: end_of_frame mismatch: expected %b, actual %b", $time,
                     want.end_of_frame, slip_if.end_of_frame);
            mismatch_count++;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        cmd_took      = 1'b1;
        seen.opcode   = cmd_if.opcode;
        seen.length   = cmd_if.payload_length;
        seen.checksum = cmd_if.payload_checksum;
        seen.data     = cmd_if.data_byte;
        seen.first    = cmd_if.first_byte;
        seen.last     = cmd_if.last_byte;
        seen.gap      = 0;
        seen.drain    = 1'b0;
        frame_and_escape(seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, build the item list, wait for everything to come
  // out, then report.
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned counted;
    int unsigned frame_idx;
    int unsigned n_bytes;
    bit          gen_open;
    bit          abandon;

    rst                     = 1'b1;
    cmd_if.valid            = 1'b0;
    cmd_if.opcode           = '0;
    cmd_if.payload_length   = '0;
    cmd_if.payload_checksum = '0;
    cmd_if.data_byte        = '0;
    cmd_if.first_byte       = 1'b0;
    cmd_if.last_byte        = 1'b0;
    slip_if.ready           = 1'b0;
    frame_open              = 1'b0;
    hdr_shadow              = '0;
    mismatch_count          = 0;
    cycle_count             = 0;
    slip_count              = 0;
    cmd_took                = 1'b0;
    slip_took               = 1'b0;
    staged                  = 1'b0;
    wait_left               = 0;
    stall_left              = 0;
    hold_left               = 0;
    hold_done               = 1'b0;
    calm_stretch            = 1'b0;

    // Directed part.
    // Bytes outside any frame are dropped, even one marked last.
    add_item(8'h11, 16'h2222, 32'h33333333, 8'h55, 1'b0, 1'b0, 1'b0);
    add_item(8'h11, 16'h2222, 32'h33333333, 8'hC0, 1'b0, 1'b1, 1'b0);
    // A header whose opcode, length and checksum bytes all need escaping, then payload
    // bytes covering both escapes and the extremes.
    add_item(SLIP_END, {SLIP_ESC, SLIP_END}, {SLIP_END, SLIP_ESC, SLIP_END, SLIP_ESC},
             SLIP_END, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 16'h0000, 32'h0, SLIP_ESC, 1'b0, 1'b0, 1'b0);
    add_item(8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 1'b0);
    add_item(8'h00, 16'h0000, 32'h0, 8'hFF, 1'b0, 1'b1, 1'b0);
    // Single-byte frames: first and last on the same item, all-ones and
    // all-zeros headers. The first of them waits for a full drain.
    add_item(8'hFF, 16'hFFFF, 32'hFFFFFFFF, SLIP_ESC, 1'b1, 1'b1, 1'b1);
    add_item(8'h00, 16'h0000, 32'h00000000, 8'h00, 1'b1, 1'b1, 1'b0);
    // Stray byte after a closed frame.
    add_item(8'hA5, 16'h5A5A, 32'hA5A5A5A5, 8'h7E, 1'b0, 1'b0, 1'b0);
    // A frame abandoned by a new first byte, which then runs to its end.
    add_item(8'h01, 16'h0003, 32'h12345678, 8'h12, 1'b1, 1'b0, 1'b0);
    add_item(8'h02, 16'h0000, 32'h00000000, 8'h34, 1'b0, 1'b0, 1'b0);
    add_item(SLIP_ESC, 16'h00C0, 32'hDB0000C0, SLIP_END, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 16'h0000, 32'h0, 8'h80, 1'b0, 1'b0, 1'b0);
    add_item(8'h00, 16'h0000, 32'h0, 8'h01, 1'b0, 1'b1, 1'b0);
    // Abandon a frame with a single-byte frame.
    add_item(8'h7F, 16'h8000, 32'h80000000, 8'h7F, 1'b1, 1'b0, 1'b0);
    add_item(8'h80, 16'h7FFF, 32'h7FFFFFFF, SLIP_ESC, 1'b1, 1'b1, 1'b0);
    add_item(8'h00, 16'h0000, 32'h0, 8'h00, 1'b0, 1'b1, 1'b0);

    // Random part: mostly well-formed frames with random content, some
    // stray bytes between frames and some frames cut short by the next one.
    // Every sixth frame goes out back to back with no sender gaps.
    counted   = 0;
    frame_idx = 0;
    gen_open  = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      frame_idx++;
      calm_stretch = (frame_idx % 6) == 0;
      if (!gen_open && $urandom_range(0, 7) == 0) begin
        add_item(pick8(), 16'($urandom), $urandom, pick8(), 1'b0, 1'($urandom), 1'b0);
      end
      n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      abandon = $urandom_range(0, 11) == 0;
      for (int k = 0; k < n_bytes; k++) begin
        add_item(pick8(), {pick8(), pick8()}, {pick8(), pick8(), pick8(), pick8()},
                 pick8(), k == 0, (k == n_bytes - 1) && !abandon,
                 (k == 0) && (frame_idx == 40));
        counted++;
      end
      gen_open = abandon;
    end
    // Close whatever frame is still open.
    calm_stretch = 1'b0;
    add_item(pick8(), 16'($urandom), $urandom, pick8(), 1'b1, 1'b1, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (payload_items_q.size() != 0 || staged || cmd_if.valid ||
           slip_bytes_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (slip_bytes_q.size() != 0) begin
      $display("%0t: missing wire bytes: expected %0d more, actual 0", $time,
               slip_bytes_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cpsf_pkg.sv
rtl/cpsf_in_if.sv
rtl/cpsf_out_if.sv
rtl/cpsf_emitter.sv
rtl/cpsf_out_reg.sv
rtl/command_packet_slip_framer.sv
tb/tb_top.sv
